/* rtl/core/sst_pkg.sv */
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the sorted set table
// Request modes, sequencer states, cell control word and fixed field widths.
// ----------------------------------------------------------------------------
package sst_pkg;

  // fixed field widths
  localparam int MODE_W      = 2;
  localparam int KEY_W       = 16;
  localparam int COUNT_W     = 11;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // request modes; the fourth code is unused and changes nothing
  typedef enum logic [MODE_W-1:0] {
    MODE_MEMBER = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2
  } mode_t;

  // request sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_APPLY
  } state_t;

  // control word broadcast to every cell
  typedef struct packed {
    logic compare_en;
    logic insert_en;
    logic delete_en;
  } cell_ctrl_t;

endpackage

/* rtl/core/sorted_set_table.sv */
// ----------------------------------------------------------------------------
// sorted_set_table: bounded set of distinct values kept in ascending order
// Flow: an accepted request passes the compare stage and then the shift stage
// of the cell row before its result word is registered; no new request is
// taken until then, and a result held on the output stalls the shift.
// Reset: fill count cleared, table empty; slot contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_set_table #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sst_pkg::IN_TDATA_W-1:0] s_tdata,   // [1:0] mode, [17:2] key_value
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sst_pkg::OUT_TDATA_W-1:0] m_tdata   // [0] success, [1] full_reject,
                                                    // [12:2] entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  sst_pkg::state_t       state;
  sst_pkg::state_t       state_next;
  sst_pkg::cell_ctrl_t   ctrl;

  logic [sst_pkg::MODE_W-1:0] mode;
  logic [VALUE_BITS-1:0]      key;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;

  logic                       success;
  logic                       full_reject;
  logic [sst_pkg::COUNT_W-1:0] entry_count;

  logic                       apply_fire;
  logic                       present;
  logic                       store_full;
  logic                       insert_go;
  logic                       delete_go;
  logic                       success_next;
  logic                       full_next;
  logic [CNT_W+sst_pkg::COUNT_W-1:0] count_ext;

  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]   cell_lt;
  logic [CAPACITY-1:0]   cell_eq;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sst_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = sst_pkg::ST_COMPARE;
      end
      sst_pkg::ST_COMPARE: begin
        state_next = sst_pkg::ST_APPLY;
      end
      sst_pkg::ST_APPLY: begin
        if (!m_tvalid || m_tready) state_next = sst_pkg::ST_IDLE;
      end
      default: begin
        state_next = sst_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready        = (state == sst_pkg::ST_IDLE);
    apply_fire      = (state == sst_pkg::ST_APPLY) && (!m_tvalid || m_tready);
    ctrl.compare_en = (state == sst_pkg::ST_COMPARE);
    ctrl.insert_en  = apply_fire && insert_go;
    ctrl.delete_en  = apply_fire && delete_go;
  end

  // decision from the registered cell flags
  assign present    = |cell_eq;
  assign store_full = (count == CNT_W'(CAPACITY));

  always_comb begin
    insert_go    = 1'b0;
    delete_go    = 1'b0;
    success_next = 1'b0;
    full_next    = 1'b0;
    count_next   = count;
    case (mode)
      sst_pkg::MODE_MEMBER: begin
        success_next = present;
      end
      sst_pkg::MODE_INSERT: begin
        if (!present) begin
          if (store_full) begin
            full_next = 1'b1;
          end else begin
            insert_go    = 1'b1;
            success_next = 1'b1;
            count_next   = count + CNT_W'(1);
          end
        end
      end
      sst_pkg::MODE_DELETE: begin
        if (present) begin
          delete_go    = 1'b1;
          success_next = 1'b1;
          count_next   = count - CNT_W'(1);
        end
      end
      default: begin
        success_next = 1'b0;
      end
    endcase
  end

  // sequencer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sst_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (apply_fire) count <= count_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mode <= s_tdata[sst_pkg::MODE_W-1:0];
      key  <= VALUE_BITS'(s_tdata[sst_pkg::MODE_W +: sst_pkg::KEY_W]);
    end
  end

  // output register
  assign count_ext = {{sst_pkg::COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (apply_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      success     <= success_next;
      full_reject <= full_next;
      entry_count <= count_ext[sst_pkg::COUNT_W-1:0];
    end
  end

  assign m_tdata = {{(sst_pkg::OUT_TDATA_W - sst_pkg::COUNT_W - 2){1'b0}},
                    entry_count, full_reject, success};

  // row of cells, each linked to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_value;
    logic                  left_lt;
    logic [VALUE_BITS-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_value = key;
      assign left_lt    = 1'b1;
    end else begin : g_link
      assign left_value = cell_value[i-1];
      assign left_lt    = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_next
      assign right_value = cell_value[i+1];
    end

    sst_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (key),
      .count       (count),
      .left_value  (left_value),
      .left_lt     (left_lt),
      .right_value (right_value),
      .value       (cell_value[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i])
    );
  end

  // a refused insert never reports success
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(success && full_reject))
    else $error("full_reject with success set");

  // fill count stays within capacity
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // fill count moves by at most one per request
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count)) || (count == $past(count) + CNT_W'(1)) ||
             (count == $past(count) - CNT_W'(1)))
    else $error("fill count jumped");

  // an accepted request always goes to the compare stage
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == sst_pkg::ST_COMPARE))
    else $error("accepted request not compared");

endmodule

/* rtl/core/sst_cell.sv */
// ----------------------------------------------------------------------------
// sst_cell: one slot of the sorted set table
// Holds one value, compares it with the broadcast key and shifts toward its
// right neighbor on insert or takes the right neighbor's value on delete.
// ----------------------------------------------------------------------------
module sst_cell #(
  parameter int VALUE_BITS = 16,
  parameter int CNT_W      = 11,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  sst_pkg::cell_ctrl_t   ctrl,
  input  logic [VALUE_BITS-1:0] key,
  input  logic [CNT_W-1:0]      count,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic                  left_lt,
  input  logic [VALUE_BITS-1:0] right_value,
  output logic [VALUE_BITS-1:0] value,
  output logic                  lt,
  output logic                  eq
);

  logic                  occupied;
  logic [VALUE_BITS-1:0] value_next;

  // slot holds a live value when it lies below the fill count
  assign occupied = CNT_W'(INDEX) < count;

  // insert: keep if below key, else take key at the boundary or shift right
  always_comb begin
    value_next = value;
    if (ctrl.insert_en) begin
      if (!lt) begin
        value_next = left_lt ? key : left_value;
      end
    end else if (ctrl.delete_en) begin
      if (!lt) begin
        value_next = right_value;
      end
    end
  end

  // compare flags, captured in the compare stage ahead of the shift
  always_ff @(posedge clk) begin
    if (ctrl.compare_en) begin
      lt <= occupied && (value < key);
      eq <= occupied && (value == key);
    end
    value <= value_next;
  end

endmodule

/* tb/tb_sorted_set_table.sv */
// ----------------------------------------------------------------------------
// tb_sorted_set_table: self-checking bench for the sorted set table
// Drives member, insert and delete requests, first from a short directed
// table and then in random phases that fill the table to capacity, work it
// while full and drain part of it again. A predictor keeps its own sorted copy
// of the held values and queues the expected reply word for every accepted
// request. Each reply word is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb_sorted_set_table;

  localparam int          CAPACITY    = 1024;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int          HOLD_CYCLES = 80;
  localparam int          STALL_LIMIT = 1000;
  localparam int          N_DIRECTED  = 25;
  localparam int          N_FULL      = 220;
  localparam int          N_DRAIN     = 460;
  localparam int          N_CALM      = 160;

  // reply fields, highest bit first as on m_tdata
  typedef struct packed {
    logic [sst_pkg::COUNT_W-1:0] entry_count;
    logic                        full_reject;
    logic                        success;
  } set_reply_t;

  typedef struct {
    logic [1:0]                mode;
    logic [sst_pkg::KEY_W-1:0] key;
    bit                        typed;
    set_reply_t                reply;
  } request_row_t;

  localparam set_reply_t NO_REPLY = '0;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [sst_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [sst_pkg::OUT_TDATA_W-1:0] m_tdata;

  logic [sst_pkg::KEY_W-1:0] held_keys [$];     // predictor copy, ascending
  set_reply_t                pending_results [$];
  int                        mismatch_count = 0;
  int                        idle_cycles = 0;
  bit                        hold_off_req = 1'b0;
  bit                        calm_tail = 1'b0;
  int                        sent_count = 0;

  request_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{sst_pkg::MODE_MEMBER, 16'h0000, 1'b1, '{11'd0, 1'b0, 1'b0}},
    '{sst_pkg::MODE_DELETE, 16'h0000, 1'b1, '{11'd0, 1'b0, 1'b0}},
    '{MODE_UNUSED,          16'hFFFF, 1'b1, '{11'd0, 1'b0, 1'b0}},
    '{sst_pkg::MODE_INSERT, 16'hFFFF, 1'b1, '{11'd1, 1'b0, 1'b1}},
    '{sst_pkg::MODE_INSERT, 16'h0000, 1'b1, '{11'd2, 1'b0, 1'b1}},
    '{sst_pkg::MODE_INSERT, 16'hFFFF, 1'b1, '{11'd2, 1'b0, 1'b0}},
    '{sst_pkg::MODE_MEMBER, 16'hFFFF, 1'b1, '{11'd2, 1'b0, 1'b1}},
    '{sst_pkg::MODE_MEMBER, 16'h0000, 1'b1, '{11'd2, 1'b0, 1'b1}},
    '{sst_pkg::MODE_MEMBER, 16'h8000, 1'b1, '{11'd2, 1'b0, 1'b0}},
    '{sst_pkg::MODE_INSERT, 16'h8000, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_INSERT, 16'h7FFF, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_INSERT, 16'h5555, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_INSERT, 16'hAAAA, 1'b0, NO_REPLY},
    '{MODE_UNUSED,          16'h5555, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_DELETE, 16'h8000, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_DELETE, 16'h8000, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_MEMBER, 16'h7FFF, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_DELETE, 16'h0000, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_DELETE, 16'hFFFF, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_INSERT, 16'h0001, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_DELETE, 16'h5555, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_DELETE, 16'hAAAA, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_DELETE, 16'h7FFF, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_DELETE, 16'h0001, 1'b0, NO_REPLY},
    '{sst_pkg::MODE_MEMBER, 16'h0001, 1'b1, '{11'd0, 1'b0, 1'b0}}
  };

  sorted_set_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // set update for one request, returns the reply it should produce
  function automatic set_reply_t predict_request(logic [1:0] mode,
                                                 logic [sst_pkg::KEY_W-1:0] key);
    int         place;
    bit         present;
    set_reply_t reply;
    place = 0;
    while (place < held_keys.size() && held_keys[place] < key) place++;
    present = (place < held_keys.size()) && (held_keys[place] == key);
    reply = '0;
    case (mode)
      sst_pkg::MODE_MEMBER: reply.success = present;
      sst_pkg::MODE_INSERT: begin
        if (!present) begin
          if (held_keys.size() >= CAPACITY) begin
            reply.full_reject = 1'b1;
          end else begin
            held_keys.insert(place, key);
            reply.success = 1'b1;
          end
        end
      end
      sst_pkg::MODE_DELETE: begin
        if (present) begin
          held_keys.delete(place);
          reply.success = 1'b1;
        end
      end
      default: ;
    endcase
    reply.entry_count = sst_pkg::COUNT_W'(held_keys.size());
    return reply;
  endfunction

  // a value currently held, or any value when the set is empty
  function automatic logic [sst_pkg::KEY_W-1:0] pick_held();
    if (held_keys.size() == 0) return sst_pkg::KEY_W'($urandom_range(0, 65535));
    return held_keys[$urandom_range(0, held_keys.size() - 1)];
  endfunction

  function automatic logic [sst_pkg::KEY_W-1:0] any_key();
    return sst_pkg::KEY_W'($urandom_range(0, 65535));
  endfunction

  // offer one request word and wait until it is taken
  task automatic offer_request(logic [1:0] mode, logic [sst_pkg::KEY_W-1:0] key,
                               bit typed = 1'b0, set_reply_t typed_reply = '0);
    set_reply_t reply;
    // sender gaps come in bursts, with every third stretch left gap-free
    if (!calm_tail && (sent_count / 40) % 3 != 2 && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(sst_pkg::IN_TDATA_W - sst_pkg::MODE_W - sst_pkg::KEY_W){1'b0}},
                 key, mode};
    do @(posedge clk); while (!s_tready);
    reply = predict_request(mode, key);
    pending_results.push_back(typed ? typed_reply : reply);
    sent_count++;
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d (t=%0t)", field, got, want, $time);
    mismatch_count++;
  endtask

  // receiver: short stall bursts, one long hold-off on request, calm at the end
  initial begin
    int rx_cycle;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!calm_tail && (rx_cycle / 50) % 3 != 1 && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // reply checker
  always @(posedge clk) begin
    set_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.success)
          report_mismatch("success", m_tdata[0], want.success);
        if (m_tdata[1] !== want.full_reject)
          report_mismatch("full_reject", m_tdata[1], want.full_reject);
        if (m_tdata[sst_pkg::COUNT_W+1:2] !== want.entry_count)
          report_mismatch("entry_count", m_tdata[sst_pkg::COUNT_W+1:2],
                          want.entry_count);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[sorted_set_table] ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int pick;
    int n;
    while (rst) @(posedge clk);

    // directed rows
    for (int i = 0; i < N_DIRECTED; i++)
      offer_request(directed_rows[i].mode, directed_rows[i].key,
                    directed_rows[i].typed, directed_rows[i].reply);

    // fill up to capacity, mostly fresh inserts
    n = 0;
    while (held_keys.size() < CAPACITY) begin
      pick = $urandom_range(0, 99);
      if (pick < 82)      offer_request(sst_pkg::MODE_INSERT, any_key());
      else if (pick < 88) offer_request(sst_pkg::MODE_INSERT, pick_held());
      else if (pick < 91) offer_request(sst_pkg::MODE_MEMBER, pick_held());
      else if (pick < 94) offer_request(sst_pkg::MODE_MEMBER, any_key());
      else if (pick < 97) offer_request(sst_pkg::MODE_DELETE, pick_held());
      else                offer_request(MODE_UNUSED, any_key());
      n++;
      // long receiver hold-off while requests keep coming
      if (n == 300) hold_off_req = 1'b1;
      // sender pause until every pending reply is back
      if (n == 600) begin
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    // work the table while it is full or nearly so
    for (int i = 0; i < N_FULL; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      offer_request(sst_pkg::MODE_INSERT, any_key());
      else if (pick < 45) offer_request(sst_pkg::MODE_INSERT, pick_held());
      else if (pick < 65) offer_request(sst_pkg::MODE_MEMBER, pick_held());
      else if (pick < 75) offer_request(sst_pkg::MODE_MEMBER, any_key());
      else if (pick < 95) offer_request(sst_pkg::MODE_DELETE, pick_held());
      else                offer_request(MODE_UNUSED, any_key());
    end

    // partial drain, with no idling at the very end
    for (int i = 0; i < N_DRAIN; i++) begin
      if (i == N_DRAIN - N_CALM) calm_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55)      offer_request(sst_pkg::MODE_DELETE, pick_held());
      else if (pick < 70) offer_request(sst_pkg::MODE_DELETE, any_key());
      else if (pick < 85) offer_request(sst_pkg::MODE_MEMBER, pick_held());
      else                offer_request(sst_pkg::MODE_INSERT, any_key());
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[sorted_set_table] OK");
    end else begin
      $display("[sorted_set_table] ERROR");
    end
    $finish;
  end

endmodule
